[rtl/core/trcpwm_pkg.sv]
// ----------------------------------------------------------------------------
// trcpwm_pkg
// Shared constants and controller/datapath interface types for the
// three-channel ratio PWM.
// ----------------------------------------------------------------------------
package trcpwm_pkg;

    localparam int DEF_PERIOD_BITS = 12;
    localparam int RESET_PERIOD    = 1000;
    localparam int SHARE_W         = 10;
    localparam int NUM_CH          = 3;
    localparam int CH_W            = 2;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEANING_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE = 2'd2;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

    typedef struct packed {
        logic            capture;
        logic            tick;
        logic            mul;
        logic            div_step;
        logic            store;
        logic            emit;
        logic [CH_W-1:0] chan;
    } cmd_t;

    typedef struct packed {
        logic cleaning;
        logic top_zero;
        logic out_free;
    } sts_t;

endpackage

[rtl/core/trcpwm_ctrl.sv]
// ----------------------------------------------------------------------------
// trcpwm_ctrl
// Sequencer for the ratio PWM: accepts one transaction at a time, runs the
// tick update or up to three share divisions, then hands over the result.
// ----------------------------------------------------------------------------
module trcpwm_ctrl
    import trcpwm_pkg::*;
#(
    parameter int DIV_STEPS = SHARE_W + DEF_PERIOD_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic s_tuser,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TICK  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_STORE = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CH_W-1:0]  chan_reg, chan_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        chan_next    = chan_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.chan     = chan_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    chan_next   = '0;
                    if (s_tuser) begin
                        state_next = S_TICK;
                    end else if (sts.cleaning) begin
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_MUL;
                    end
                end
            end
            S_TICK: begin
                cmd.tick   = 1'b1;
                state_next = S_EMIT;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                if (sts.top_zero) begin
                    state_next = S_EMIT;
                end else begin
                    cnt_next   = CNT_W'(DIV_STEPS - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_STORE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_STORE: begin
                cmd.store = 1'b1;
                if (chan_reg == LAST_CH) begin
                    state_next = S_EMIT;
                end else begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_EMIT: begin
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            chan_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[rtl/core/trcpwm_dp.sv]
// ----------------------------------------------------------------------------
// trcpwm_dp
// Datapath of the ratio PWM: configuration registers, share capture,
// multiplier and bit-serial divider, off times, elapsed counter, drive levels
// and the result register.
// ----------------------------------------------------------------------------
module trcpwm_dp
    import trcpwm_pkg::*;
#(
    parameter int PERIOD_BITS = DEF_PERIOD_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [PERIOD_BITS-1:0] cfg_wdata,
    input  logic [31:0]            s_tdata,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata
);

    localparam int ELAP_W = PERIOD_BITS + 1;
    localparam int DVD_W  = SHARE_W + PERIOD_BITS;
    localparam logic [ELAP_W-1:0] ELAP_MAX   = '1;
    localparam logic [ELAP_W-1:0] ELAP_RESET = ELAP_W'(1) << PERIOD_BITS;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(RESET_PERIOD);

    logic [PERIOD_BITS-1:0] period_reg;
    logic                   cleaning_reg;
    logic                   oe_reg;
    logic [ELAP_W-1:0]      elapsed_reg;
    logic [PERIOD_BITS-1:0] off_reg [NUM_CH];
    logic [NUM_CH-1:0]      drive_reg;
    logic                   restart_reg;
    logic [SHARE_W-1:0]     share_reg [NUM_CH];
    logic [DVD_W-1:0]       dvd_reg;
    logic [SHARE_W-1:0]     rem_reg;
    logic                   m_tvalid_reg;
    logic [3:0]             m_tdata_reg;

    logic [SHARE_W-1:0]     top;
    logic [SHARE_W:0]       trial;
    logic                   fits;
    logic [ELAP_W-1:0]      elapsed_inc;
    logic                   wrap;
    logic [PERIOD_BITS-1:0] on_raw;
    logic [PERIOD_BITS-1:0] on_val;

    always_comb begin
        top = share_reg[0];
        if (share_reg[1] > top) begin
            top = share_reg[1];
        end
        if (share_reg[2] > top) begin
            top = share_reg[2];
        end
    end

    assign trial       = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits        = (trial >= {1'b0, top});
    assign elapsed_inc = (elapsed_reg == ELAP_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign wrap        = (elapsed_inc > {1'b0, period_reg});
    assign on_raw      = dvd_reg[PERIOD_BITS-1:0];
    assign on_val      = (on_raw > period_reg) ? period_reg : on_raw;

    assign sts.cleaning = cleaning_reg;
    assign sts.top_zero = (top == '0);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_tdata_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= PERIOD_RESET;
            cleaning_reg <= 1'b0;
            oe_reg       <= 1'b0;
            elapsed_reg  <= ELAP_RESET;
            drive_reg    <= '0;
            restart_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                off_reg[i] <= PERIOD_RESET;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_CYCLE_PERIOD: begin
                        period_reg <= cfg_wdata;
                    end
                    CFG_CLEANING_MODE: begin
                        cleaning_reg <= cfg_wdata[0];
                        for (int i = 0; i < NUM_CH; i++) begin
                            off_reg[i] <= cfg_wdata[0] ? '0 : period_reg;
                        end
                    end
                    CFG_OUTPUT_ENABLE: begin
                        oe_reg    <= cfg_wdata[0];
                        drive_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.capture) begin
                restart_reg <= 1'b0;
            end
            if (cmd.tick) begin
                if (!oe_reg) begin
                    elapsed_reg <= elapsed_inc;
                    drive_reg   <= '0;
                end else if (wrap) begin
                    elapsed_reg <= '0;
                    drive_reg   <= '0;
                    restart_reg <= 1'b1;
                end else begin
                    elapsed_reg <= elapsed_inc;
                    for (int i = 0; i < NUM_CH; i++) begin
                        if (elapsed_inc > {1'b0, off_reg[i]}) begin
                            drive_reg[i] <= 1'b1;
                        end
                    end
                end
            end
            if (cmd.mul && (top == '0)) begin
                for (int i = 0; i < NUM_CH; i++) begin
                    off_reg[i] <= period_reg;
                end
            end
            if (cmd.store) begin
                off_reg[cmd.chan] <= period_reg - on_val;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            share_reg[0] <= s_tdata[SHARE_W-1:0];
            share_reg[1] <= s_tdata[2*SHARE_W-1:SHARE_W];
            share_reg[2] <= s_tdata[3*SHARE_W-1:2*SHARE_W];
        end
        if (cmd.mul) begin
            dvd_reg <= DVD_W'(share_reg[cmd.chan]) * DVD_W'(period_reg);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= fits ? SHARE_W'(trial - {1'b0, top}) : trial[SHARE_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
        end
        if (cmd.emit) begin
            m_tdata_reg <= {restart_reg, drive_reg[2], drive_reg[1], drive_reg[0]};
        end
    end

    a_disabled_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tick && !oe_reg) |=> (drive_reg == '0))
        else $error("drive active after tick while disabled");

    a_wrap_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tick && oe_reg && wrap) |=> (elapsed_reg == '0 && restart_reg && drive_reg == '0))
        else $error("cycle restart did not clear count and drives");

    a_store_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |=> (off_reg[$past(cmd.chan)] <= period_reg))
        else $error("stored off time exceeds cycle period");

    a_set_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.capture && !cmd.tick) |=> !restart_reg)
        else $error("restart flag not cleared on new transaction");

endmodule

[rtl/core/three_channel_ratio_pwm.sv]
// ----------------------------------------------------------------------------
// three_channel_ratio_pwm
// Three-channel slow PWM for pump drive, with ratio-based duty setting.
//
// Channel   Direction  tdata / tuser content
// s_        in         tdata: share_one, share_two, share_three; tuser: kind
// m_        out        tdata: pump_one_on, pump_two_on, pump_three_on, restart
// cfg_      in         cycle_period, cleaning_mode, output_enable
//
// A tick transaction passes through the tick state, then the emit state.
// A set transaction runs three multiply/divide passes on one shared divider,
// one per channel; an all-zero set ends after its first multiply step, and a
// cleaning-mode set skips the passes and goes straight to the result.
// Reset is synchronous; no clearing pass is needed.
// While a result waits, one more transaction is accepted and computed; its
// result then waits for the output register before the input opens again.
// ----------------------------------------------------------------------------
module three_channel_ratio_pwm
    import trcpwm_pkg::*;
#(
    parameter int PERIOD_BITS = DEF_PERIOD_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [PERIOD_BITS-1:0] cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // share_one, share_two, share_three
    input  logic                   s_tuser,   // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata    // pump one, two, three, cycle_restart
);

    cmd_t cmd;
    sts_t sts;

    trcpwm_ctrl #(
        .DIV_STEPS(SHARE_W + PERIOD_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tuser (s_tuser),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    trcpwm_dp #(
        .PERIOD_BITS(PERIOD_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[tb/pump_drive_checker.sv]
// ----------------------------------------------------------------------------
// pump_drive_checker
// Watches the configuration port and both stream channels of the three-channel
// ratio PWM. It keeps its own copy of the period, mode, off times, elapsed count
// and drive levels, predicts the pump levels for every accepted transaction,
// and compares each result transaction field by field with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pump_drive_checker
    import trcpwm_pkg::*;
#(
    parameter logic TICK_KIND = 1'b1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [DEF_PERIOD_BITS-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [31:0]                s_tdata,
    input  logic                       s_tuser,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [7:0]                 m_tdata,
    output int                         fail_count,
    output int                         outstanding
);

    localparam int PB = DEF_PERIOD_BITS;

    typedef struct packed {
        logic              restart;
        logic [NUM_CH-1:0] pumps;
    } pump_levels_t;

    logic [PB-1:0]     period_len;
    logic              cleaning_on;
    logic              outputs_enabled;
    logic [PB:0]       elapsed;
    logic [PB-1:0]     off_time [NUM_CH];
    logic [NUM_CH-1:0] level;

    pump_levels_t levels_due [$];
    int           errors = 0;
    string        pump_names [NUM_CH] = '{"pump_one_on", "pump_two_on", "pump_three_on"};

    function automatic void load_off_times(input logic [PB-1:0] value);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            off_time[ch] = value;
        end
    endfunction

    function automatic void reset_model();
        period_len      = PB'(RESET_PERIOD);
        cleaning_on     = 1'b0;
        outputs_enabled = 1'b0;
        elapsed         = '0;
        elapsed[PB]     = 1'b1;
        level           = '0;
        load_off_times(period_len);
        levels_due.delete();
    endfunction

    function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [PB-1:0] value);
        case (idx)
            CFG_CYCLE_PERIOD: begin
                period_len = value;
            end
            CFG_CLEANING_MODE: begin
                cleaning_on = value[0];
                load_off_times(cleaning_on ? '0 : period_len);
            end
            CFG_OUTPUT_ENABLE: begin
                outputs_enabled = value[0];
                level           = '0;
            end
            default: begin
            end
        endcase
    endfunction

    // The largest share gets the whole period; the others get their ratio of it.
    function automatic void apply_shares(input logic [NUM_CH*SHARE_W-1:0] shares);
        logic [SHARE_W-1:0] share [NUM_CH];
        logic [SHARE_W-1:0] largest;
        logic [31:0]        on_ticks;
        largest = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            share[ch] = shares[ch*SHARE_W +: SHARE_W];
            if (share[ch] > largest) begin
                largest = share[ch];
            end
        end
        if (largest == '0) begin
            load_off_times(period_len);
        end else begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                on_ticks = (32'(share[ch]) * 32'(period_len)) / 32'(largest);
                if (on_ticks > 32'(period_len)) begin
                    on_ticks = 32'(period_len);
                end
                off_time[ch] = period_len - PB'(on_ticks);
            end
        end
    endfunction

    function automatic pump_levels_t advance_pumps(input logic kind, input logic [31:0] data);
        pump_levels_t next;
        next.restart = 1'b0;
        if (kind != TICK_KIND) begin
            if (!cleaning_on) begin
                apply_shares(data[NUM_CH*SHARE_W-1:0]);
            end
        end else begin
            if (elapsed != '1) begin
                elapsed = elapsed + 1'b1;
            end
            if (!outputs_enabled) begin
                level = '0;
            end else begin
                if (elapsed > {1'b0, period_len}) begin
                    elapsed      = '0;
                    level        = '0;
                    next.restart = 1'b1;
                end
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    if (elapsed > {1'b0, off_time[ch]}) begin
                        level[ch] = 1'b1;
                    end
                end
            end
        end
        next.pumps = level;
        return next;
    endfunction

    function automatic void note_mismatch(input string field, input logic want, input logic got);
        errors++;
        $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    endfunction

    always @(posedge aclk) begin
        pump_levels_t want;
        pump_levels_t got;
        if (!aresetn) begin
            reset_model();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[NUM_CH:0];
                if (levels_due.size() == 0) begin
                    errors++;
                    $display("%0t ns: result transaction with none expected, got %b",
                             $time, got);
                end else begin
                    want = levels_due.pop_front();
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        if (want.pumps[ch] !== got.pumps[ch]) begin
                            note_mismatch(pump_names[ch], want.pumps[ch], got.pumps[ch]);
                        end
                    end
                    if (want.restart !== got.restart) begin
                        note_mismatch("cycle_restart", want.restart, got.restart);
                    end
                end
            end
            if (cfg_wr_en) begin
                write_register(cfg_index, cfg_wdata);
            end
            if (s_tvalid && s_tready) begin
                levels_due.push_back(advance_pumps(s_tuser, s_tdata));
            end
        end
        fail_count  <= errors;
        outstanding <= levels_due.size();
    end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the three-channel ratio PWM. After reset it runs a
// short stretch of ticks with outputs disabled, then a short directed
// sequence over the share extremes, cleaning mode, period limits and enable,
// then random phases with new register settings, bursty input and a stalling
// receiver. A separate checker predicts and compares every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import trcpwm_pkg::*;

    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_TICK = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int            PB             = DEF_PERIOD_BITS;
    localparam logic [PB-1:0] PERIOD_MAX     = '1;
    localparam int            SHARE_FULL     = 1000;
    localparam int            SHARE_TOP      = (1 << SHARE_W) - 1;
    localparam int            RANDOM_ITEMS   = 1860;
    localparam int            DISABLED_TICKS = 40;
    localparam int            HOLD_CYCLES    = 400;
    localparam int            SETTLE_CYCLES  = 80;
    localparam int            CYCLE_LIMIT    = 1500000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PB-1:0]        cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic [31:0]          s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tready  = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [7:0]           m_tdata;

    int   fail_count;
    int   outstanding;
    int   stall_pct     = 0;
    int   gap_max       = 0;
    int   burst_max     = 0;
    int   burst_left    = 0;
    int   hold_requests = 0;
    int   holds_served  = 0;
    int   hold_left     = 0;
    int   cycle_count   = 0;
    logic cleaning_now  = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    three_channel_ratio_pwm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    pump_drive_checker #(
        .TICK_KIND (KIND_TICK)
    ) pump_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[three_channel_ratio_pwm] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            m_tready     <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [SHARE_W-1:0] pick_share();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SHARE_W'(SHARE_FULL);
            2: return SHARE_W'($urandom_range(SHARE_FULL + 1, SHARE_TOP));
            3: return SHARE_W'(1);
            default: return SHARE_W'($urandom_range(0, SHARE_FULL));
        endcase
    endfunction

    task automatic send_item(input logic kind, input logic [SHARE_W-1:0] one,
                             input logic [SHARE_W-1:0] two, input logic [SHARE_W-1:0] three);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, three, two, one};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, burst_max);
            gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, pick_share(), pick_share(), pick_share());
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PB-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_flag(input logic [CFG_IDX_W-1:0] idx, input logic flag);
        logic [PB-1:0] value;
        value    = PB'($urandom);
        value[0] = flag;
        write_reg(idx, value);
    endtask

    initial begin
        int                 random_sent;
        int                 phase;
        int                 items;
        int                 set_pct;
        int                 pick;
        logic [SHARE_W-1:0] a;
        logic [SHARE_W-1:0] b;
        logic [SHARE_W-1:0] c;
        logic [PB-1:0]      period;
        random_sent = 0;
        phase       = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Outputs are disabled after reset, so ticks only advance the elapsed count.
        send_item(KIND_SET, SHARE_W'(SHARE_FULL), SHARE_W'(500), '0);
        repeat (DISABLED_TICKS) send_tick();
        wait_idle();
        write_reg(CFG_CYCLE_PERIOD, PB'(7));
        write_reg(CFG_OUTPUT_ENABLE, PB'(1));

        send_tick();
        send_item(KIND_SET, SHARE_W'(SHARE_FULL), SHARE_W'(500), SHARE_W'(250));
        repeat (6) send_tick();
        send_item(KIND_SET, '0, '0, '0);
        repeat (2) send_tick();
        send_item(KIND_SET, SHARE_W'(SHARE_TOP), SHARE_W'(1), '0);
        repeat (3) send_tick();
        wait_idle();
        write_reg(CFG_CLEANING_MODE, PB'(1));
        cleaning_now = 1'b1;
        send_item(KIND_SET, SHARE_W'(500), SHARE_W'(500), SHARE_W'(500));
        send_tick();
        wait_idle();
        write_reg(CFG_CLEANING_MODE, '0);
        cleaning_now = 1'b0;
        write_reg(CFG_SPARE, PERIOD_MAX);
        write_reg(CFG_CYCLE_PERIOD, PERIOD_MAX);
        send_tick();
        send_item(KIND_SET, SHARE_W'(SHARE_TOP), SHARE_W'(SHARE_TOP), SHARE_W'(SHARE_TOP));
        wait_idle();
        write_reg(CFG_CYCLE_PERIOD, PB'(1));
        repeat (3) send_tick();
        wait_idle();
        write_reg(CFG_CYCLE_PERIOD, '0);
        send_item(KIND_SET, SHARE_W'(7), SHARE_W'(3), '0);
        repeat (2) send_tick();
        wait_idle();
        write_reg(CFG_OUTPUT_ENABLE, '0);
        send_tick();

        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                period = PERIOD_MAX;
            end else if (pick == 1) begin
                period = PB'(1);
            end else if (pick == 2) begin
                period = PB'($urandom_range(100, PERIOD_MAX - 1));
            end else begin
                period = PB'($urandom_range(2, 40));
            end
            if ($urandom_range(0, 3) != 0) begin
                write_reg(CFG_CYCLE_PERIOD, period);
            end
            if ($urandom_range(0, 5) == 0) begin
                write_flag(CFG_CLEANING_MODE, 1'b1);
                cleaning_now = 1'b1;
            end else if (cleaning_now || $urandom_range(0, 3) == 0) begin
                write_flag(CFG_CLEANING_MODE, 1'b0);
                cleaning_now = 1'b0;
            end
            if (phase == 0 || $urandom_range(0, 1) == 0) begin
                write_flag(CFG_OUTPUT_ENABLE, phase == 0 || $urandom_range(0, 9) != 0);
            end

            case ($urandom_range(0, 4))
                0: stall_pct <= 0;
                1: stall_pct <= 10;
                2: stall_pct <= 30;
                3: stall_pct <= 60;
                default: stall_pct <= 85;
            endcase
            case ($urandom_range(0, 3))
                0: gap_max = 0;
                1: gap_max = 2;
                2: gap_max = 6;
                default: gap_max = 15;
            endcase
            burst_max = $urandom_range(0, 12);
            // The receiver holds off for a long stretch while the sender keeps offering.
            if (phase % 8 == 3) begin
                hold_requests <= hold_requests + 1;
                gap_max = 0;
            end

            items   = (pick == 0) ? $urandom_range(5, 20) : $urandom_range(15, 60);
            set_pct = $urandom_range(3, 30);
            repeat (items) begin
                if ($urandom_range(0, 99) < set_pct) begin
                    a = pick_share();
                    b = pick_share();
                    c = pick_share();
                    case ($urandom_range(0, 19))
                        0: begin
                            a = '0;
                            b = '0;
                            c = '0;
                        end
                        1: begin
                            b = a;
                            c = a;
                        end
                        default: begin
                        end
                    endcase
                    send_item(KIND_SET, a, b, c);
                end else begin
                    send_tick();
                end
                random_sent++;
            end
            phase++;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[three_channel_ratio_pwm] OK");
        end else begin
            $display("[three_channel_ratio_pwm] ERROR");
        end
        $finish;
    end

endmodule
